FILE: sv/pmx_pkg.sv
// ============================================================================
// pmx_pkg: shared types and constants of the Pareto maxima core
// Default sizes, the fixed result index width and the control bundle that the
// back-end sequencer drives into the cell array.
// ============================================================================
package pmx_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int INDEX_WIDTH     = 6;
    localparam int QUEUE_DEPTH     = 4;

    // Commands from the sequencer to the cell array.
    typedef struct packed {
        logic insert;   // compare the head item against all cells and store it
        logic shift;    // move every cell down by one place toward cell 0
    } cell_ctrl_t;

endpackage

FILE: sv/pareto_maxima_2d_core.sv
// ============================================================================
// pareto_maxima_2d_core: skyline (maximal points) of a 2D point set
// Throughput: one point per cycle while the queue has room; a final point holds
// the back end while the cell array shifts its stored points out toward cell 0.
// Path: a point passes through the input queue into the cells; the last survivor
// of a set goes from the cells through the held-survivor register into the output
// register when the scan of the stored points ends and the sink takes the output.
// Reset: synchronous, active low; clears queue, state, counters, flags and output valid only.
// ============================================================================
module pareto_maxima_2d_core #(
    parameter int MAX_POINTS  = pmx_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = pmx_pkg::COORD_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [COORD_WIDTH-1:0]    s_point_x,
    input  logic signed [COORD_WIDTH-1:0]    s_point_y,
    input  logic                             s_final_point,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [pmx_pkg::INDEX_WIDTH-1:0]  m_kept_index,
    output logic signed [COORD_WIDTH-1:0]    m_kept_x,
    output logic signed [COORD_WIDTH-1:0]    m_kept_y,
    output logic                             m_end_of_set,
    output logic                             m_overflowed
);
    import pmx_pkg::*;

    // A queue beat packs the final marker above the x and y coordinates.
    localparam int ITEM_W = 2 * COORD_WIDTH + 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);

    logic [ITEM_W-1:0]             s_item;
    logic [ITEM_W-1:0]             q_item;
    logic                          q_valid;
    logic                          q_pop;
    logic signed [COORD_WIDTH-1:0] q_x;
    logic signed [COORD_WIDTH-1:0] q_y;
    logic                          q_final;
    cell_ctrl_t                    cell_ctrl;
    logic [CNT_W-1:0]              point_count;
    logic signed [COORD_WIDTH-1:0] head_x;
    logic signed [COORD_WIDTH-1:0] head_y;
    logic                          head_alive;

    assign s_item  = {s_final_point, s_point_x, s_point_y};
    assign q_final = q_item[ITEM_W-1];
    assign q_x     = q_item[2*COORD_WIDTH-1:COORD_WIDTH];
    assign q_y     = q_item[COORD_WIDTH-1:0];

    // The front end only buffers beats, so the input side keeps accepting, until the
    // queue is full, while the back end is busy emitting the survivors of a set.
    pmx_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_data  (s_item),
        .head_valid (q_valid),
        .head_data  (q_item),
        .pop        (q_pop)
    );

    // Every stored point is compared with the queue head in parallel. Points
    // that the head covers lose their alive flag; the head itself is stored
    // alive, if the array has room, unless a stored point is at least as large in both and differs.
    pmx_cells #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cells (
        .aclk       (aclk),
        .ctrl       (cell_ctrl),
        .count      (point_count),
        .new_x      (q_x),
        .new_y      (q_y),
        .head_x     (head_x),
        .head_y     (head_y),
        .head_alive (head_alive)
    );

    // The sequencer holds one survivor back while scanning, so that the last
    // one can be marked as the end of the set when the scan finishes.
    pmx_back #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_final      (q_final),
        .q_pop        (q_pop),
        .ctrl         (cell_ctrl),
        .count        (point_count),
        .head_x       (head_x),
        .head_y       (head_y),
        .head_alive   (head_alive),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kept_index (m_kept_index),
        .m_kept_x     (m_kept_x),
        .m_kept_y     (m_kept_y),
        .m_end_of_set (m_end_of_set),
        .m_overflowed (m_overflowed)
    );

endmodule

FILE: sv/pmx_queue.sv
// ============================================================================
// pmx_queue: input queue of the Pareto maxima core
// Small register FIFO that takes input beats and holds them for the back end.
// ============================================================================
module pmx_queue #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data,
    input  logic             pop
);
    import pmx_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

FILE: sv/pmx_cells.sv
// ============================================================================
// pmx_cells: point cell array of the Pareto maxima core
// One cell per stored point. Every cell compares its point with the arriving
// one in parallel; during emission the array shifts toward cell 0.
// ============================================================================
module pmx_cells #(
    parameter int MAX_POINTS  = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                               aclk,
    input  pmx_pkg::cell_ctrl_t                ctrl,
    input  logic [$clog2(MAX_POINTS+1)-1:0]    count,
    input  logic signed [COORD_WIDTH-1:0]      new_x,
    input  logic signed [COORD_WIDTH-1:0]      new_y,
    output logic signed [COORD_WIDTH-1:0]      head_x,
    output logic signed [COORD_WIDTH-1:0]      head_y,
    output logic                               head_alive
);
    import pmx_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic signed [COORD_WIDTH-1:0] x_reg     [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] y_reg     [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] up_x      [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] up_y      [MAX_POINTS];
    logic [MAX_POINTS-1:0]         alive_reg;
    logic [MAX_POINTS-1:0]         up_alive;
    logic [MAX_POINTS-1:0]         beaten_by;
    logic [MAX_POINTS-1:0]         covered;
    logic                          new_alive;

    // The new point survives unless a stored point is at least as large in
    // both coordinates and differs from it.
    assign new_alive = ~|beaten_by;

    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        logic in_use;

        assign in_use = (IDX < count);
        assign beaten_by[i] = in_use && (x_reg[i] >= new_x) && (y_reg[i] >= new_y)
                              && ((x_reg[i] != new_x) || (y_reg[i] != new_y));
        assign covered[i]   = in_use && (new_x >= x_reg[i]) && (new_y >= y_reg[i]);

        if (i < MAX_POINTS - 1) begin : g_mid
            assign up_x[i]     = x_reg[i+1];
            assign up_y[i]     = y_reg[i+1];
            assign up_alive[i] = alive_reg[i+1];
        end else begin : g_top
            assign up_x[i]     = x_reg[i];
            assign up_y[i]     = y_reg[i];
            assign up_alive[i] = alive_reg[i];
        end

        always_ff @(posedge aclk) begin
            if (ctrl.shift) begin
                x_reg[i]     <= up_x[i];
                y_reg[i]     <= up_y[i];
                alive_reg[i] <= up_alive[i];
            end else if (ctrl.insert) begin
                if (IDX == count) begin
                    x_reg[i]     <= new_x;
                    y_reg[i]     <= new_y;
                    alive_reg[i] <= new_alive;
                end else if (covered[i]) begin
                    alive_reg[i] <= 1'b0;
                end
            end
        end
    end

    assign head_x     = x_reg[0];
    assign head_y     = y_reg[0];
    assign head_alive = alive_reg[0];

endmodule

FILE: sv/pmx_back.sv
// ============================================================================
// pmx_back: back-end sequencer of the Pareto maxima core
// Takes items from the queue, drives the cell array, then walks the stored
// points on a final item and delivers the survivors through an output register.
// ============================================================================
module pmx_back #(
    parameter int MAX_POINTS  = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    q_valid,
    input  logic                                    q_final,
    output logic                                    q_pop,
    output pmx_pkg::cell_ctrl_t                     ctrl,
    output logic [$clog2(MAX_POINTS+1)-1:0]         count,
    input  logic signed [COORD_WIDTH-1:0]           head_x,
    input  logic signed [COORD_WIDTH-1:0]           head_y,
    input  logic                                    head_alive,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [pmx_pkg::INDEX_WIDTH-1:0]         m_kept_index,
    output logic signed [COORD_WIDTH-1:0]           m_kept_x,
    output logic signed [COORD_WIDTH-1:0]           m_kept_y,
    output logic                                    m_end_of_set,
    output logic                                    m_overflowed
);
    import pmx_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [2:0] {
        ST_ACCEPT = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FLUSH  = 3'b100
    } state_t;

    state_t                        state_reg;
    logic [CNT_W-1:0]              count_reg;
    logic                          ovf_reg;
    logic [IDX_W-1:0]              scan_idx_reg;
    logic                          pend_valid_reg;
    logic [IDX_W-1:0]              pend_idx_reg;
    logic signed [COORD_WIDTH-1:0] pend_x_reg;
    logic signed [COORD_WIDTH-1:0] pend_y_reg;
    logic                          m_valid_reg;
    logic [INDEX_WIDTH-1:0]        m_index_reg;
    logic signed [COORD_WIDTH-1:0] m_x_reg;
    logic signed [COORD_WIDTH-1:0] m_y_reg;
    logic                          m_end_reg;
    logic                          m_ovf_reg;
    logic                          out_free;
    logic                          full;
    logic                          scan_last;
    logic                          step;
    logic                          m_load;

    assign out_free  = !m_valid_reg || m_ready;
    assign full      = (count_reg == CNT_W'(MAX_POINTS));
    assign scan_last = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);
    assign step      = (state_reg == ST_SCAN) && out_free;
    // The held survivor moves to the output register when the scan finds the
    // next one, or when the scan is over.
    assign m_load    = pend_valid_reg
                       && ((step && head_alive) || ((state_reg == ST_FLUSH) && out_free));

    always_comb begin
        q_pop       = 1'b0;
        ctrl.insert = 1'b0;
        ctrl.shift  = 1'b0;
        case (state_reg)
            ST_ACCEPT: begin
                q_pop       = q_valid;
                ctrl.insert = q_valid && !full;
            end
            ST_SCAN: begin
                ctrl.shift = out_free;
            end
            ST_FLUSH: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_ACCEPT;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_ACCEPT: begin
                    if (q_valid) begin
                        if (full) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        if (q_final) begin
                            state_reg      <= ST_SCAN;
                            scan_idx_reg   <= '0;
                            pend_valid_reg <= 1'b0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (step) begin
                        if (head_alive) begin
                            pend_valid_reg <= 1'b1;
                        end
                        if (scan_last) begin
                            state_reg <= ST_FLUSH;
                        end else begin
                            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                        end
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        pend_valid_reg <= 1'b0;
                        count_reg      <= '0;
                        ovf_reg        <= 1'b0;
                        state_reg      <= ST_ACCEPT;
                    end
                end
                default: begin
                    state_reg <= ST_ACCEPT;
                end
            endcase
        end
    end

    // Payload registers: the pending survivor and the output register.
    always_ff @(posedge aclk) begin
        if (step && head_alive) begin
            pend_idx_reg <= scan_idx_reg;
            pend_x_reg   <= head_x;
            pend_y_reg   <= head_y;
            if (pend_valid_reg) begin
                m_index_reg <= INDEX_WIDTH'(pend_idx_reg);
                m_x_reg     <= pend_x_reg;
                m_y_reg     <= pend_y_reg;
                m_end_reg   <= 1'b0;
                m_ovf_reg   <= ovf_reg;
            end
        end else if ((state_reg == ST_FLUSH) && out_free) begin
            m_index_reg <= INDEX_WIDTH'(pend_idx_reg);
            m_x_reg     <= pend_x_reg;
            m_y_reg     <= pend_y_reg;
            m_end_reg   <= 1'b1;
            m_ovf_reg   <= ovf_reg;
        end
    end

    assign count        = count_reg;
    assign m_valid      = m_valid_reg;
    assign m_kept_index = m_index_reg;
    assign m_kept_x     = m_x_reg;
    assign m_kept_y     = m_y_reg;
    assign m_end_of_set = m_end_reg;
    assign m_overflowed = m_ovf_reg;

endmodule
